/* sv/tps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the trapezoidal profile set-point unit.
// No dependencies; imported by tps_mag and the top level.
package tps_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QUAD_SHIFT  = 2 * FRAC_BITS + 1;
    localparam int LIN_SHIFT   = FRAC_BITS + 1;

    localparam int DATA_W      = 32;
    localparam int ARG_W       = DATA_W + 1;
    localparam int SQ_W        = 2 * DATA_W;
    localparam int PROD_W      = 3 * DATA_W;
    localparam int MAG_W       = 41;
    localparam int VAL_W       = MAG_W + 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROFILE_MODE   = 3'd0,
        CFG_DIRECTION      = 3'd1,
        CFG_START_POSITION = 3'd2,
        CFG_END_POSITION   = 3'd3,
        CFG_ACCEL_TIME     = 3'd4,
        CFG_TOTAL_TIME     = 3'd5,
        CFG_ACCEL_RATE     = 3'd6,
        CFG_CRUISE_SPEED   = 3'd7
    } t_cfg_idx;

    // Magnitude request: quad selects coef*arg^2 >> QUAD_SHIFT,
    // otherwise coef*arg >> LIN_SHIFT.
    typedef struct packed {
        logic              quad;
        logic [ARG_W-1:0]  arg;
        logic [DATA_W-1:0] coef;
        t_phase            phase;
    } t_mag_req;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        t_phase           phase;
    } t_mag_rsp;

endpackage

/* sv/tps_mag.sv */
`timescale 1ns / 1ps
// Four-stage magnitude pipeline: square, split 32x64 multiply, combine, shift and cap.
// Depends on tps_pkg.
module tps_mag import tps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_mag_req i_req,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_mag_rsp o_rsp
);

    logic [3:0] r_valid;
    logic [3:0] w_adv;

    // stage 0: square of the argument, or the argument itself when linear
    logic              r_quad0;
    logic [DATA_W-1:0] r_coef0;
    t_phase            r_phase0;
    logic [SQ_W-1:0]   r_b0;
    logic [SQ_W-1:0]   n_b0;
    logic [SQ_W-1:0]   w_sq;

    // stage 1: two partial products
    logic              r_quad1;
    t_phase            r_phase1;
    logic [SQ_W-1:0]   r_lo1;
    logic [SQ_W-1:0]   r_hi1;

    // stage 2: full product
    logic              r_quad2;
    t_phase            r_phase2;
    logic [PROD_W-1:0] r_sum2;
    logic [PROD_W-1:0] n_sum2;

    // stage 3: scaled, capped magnitude
    t_phase            r_phase3;
    logic [MAG_W-1:0]  r_mag3;
    logic [MAG_W-1:0]  n_mag3;
    logic [PROD_W-1:0] w_sh;

    always_comb begin
        w_adv[3] = !r_valid[3] || i_rsp_ready;
        for (int k = 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    assign o_req_ready = w_adv[0];
    assign o_rsp_valid = r_valid[3];
    assign o_rsp.mag   = r_mag3;
    assign o_rsp.phase = r_phase3;

    assign w_sq   = i_req.arg[DATA_W-1:0] * i_req.arg[DATA_W-1:0];
    assign n_b0   = i_req.quad ? w_sq : SQ_W'(i_req.arg);
    assign n_sum2 = {{DATA_W{1'b0}}, r_lo1} + {r_hi1, {DATA_W{1'b0}}};

    always_comb begin
        w_sh   = r_quad2 ? (r_sum2 >> QUAD_SHIFT) : (r_sum2 >> LIN_SHIFT);
        n_mag3 = (w_sh > PROD_W'(MAG_CAP)) ? MAG_CAP : w_sh[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_adv[0]) r_valid[0] <= i_req_valid;
            for (int k = 1; k < 4; k++) begin
                if (w_adv[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_quad0  <= i_req.quad;
            r_coef0  <= i_req.coef;
            r_phase0 <= i_req.phase;
            r_b0     <= n_b0;
        end
        if (w_adv[1]) begin
            r_quad1  <= r_quad0;
            r_phase1 <= r_phase0;
            r_lo1    <= r_coef0 * r_b0[DATA_W-1:0];
            r_hi1    <= r_coef0 * r_b0[SQ_W-1:DATA_W];
        end
        if (w_adv[2]) begin
            r_quad2  <= r_quad1;
            r_phase2 <= r_phase1;
            r_sum2   <= n_sum2;
        end
        if (w_adv[3]) begin
            r_phase3 <= r_phase2;
            r_mag3   <= n_mag3;
        end
    end

    a_mag_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[3] |-> r_mag3 <= MAG_CAP)
        else $error("magnitude above cap");

    a_lin_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && !r_quad0 |-> r_b0[SQ_W-1:ARG_W] == '0)
        else $error("linear operand wider than argument");

    a_lin_hi_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && !r_quad1 |-> r_hi1[SQ_W-1:DATA_W] == '0)
        else $error("linear upper partial product too wide");

endmodule

/* sv/trapezoidal_profile_setpoint_unit.sv */
`timescale 1ns / 1ps
// Trapezoidal / bang-bang move profile set-point generator, top level.
// Depends on tps_pkg and tps_mag.
//
// Usage:
//   Sample channel (i_sample_valid / o_sample_ready, i_sample_time): one time
//   sample per item, unsigned Q16.16 seconds since move start.
//   Result channel (o_result_valid / i_result_ready, o_set_point, o_phase):
//   one item per sample, in order: saturated Q16.16 position and phase
//   (0 none, 1 accelerate, 2 cruise, 3 decelerate).
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
//   always ready; write registers only while no item is in flight.
// Registered stages from sample accept to result valid, in order: phase
// decode, square, split multiply, product combine, shift/cap, add/saturate.
// One item per cycle while results drain; each stage holds one item and the
// stages advance independently, so a stalled receiver fills the pipeline
// one stage at a time before o_sample_ready drops, and nothing is lost.
// Reset clears the configuration registers to zero and empties the pipeline.
module trapezoidal_profile_setpoint_unit import tps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_sample_valid,
    output logic                 o_sample_ready,
    input  logic [DATA_W-1:0]    i_sample_time,
    output logic                 o_result_valid,
    input  logic                 i_result_ready,
    output logic signed [DATA_W-1:0] o_set_point,
    output logic [1:0]           o_phase
);

    // configuration registers
    logic                     r_profile_mode;
    logic                     r_direction;
    logic signed [DATA_W-1:0] r_start_position;
    logic signed [DATA_W-1:0] r_end_position;
    logic [DATA_W-1:0]        r_accel_time;
    logic [DATA_W-1:0]        r_total_time;
    logic [DATA_W-1:0]        r_accel_rate;
    logic [DATA_W-1:0]        r_cruise_speed;

    // stage 1: phase decode
    logic       r_s1_valid;
    t_mag_req   r_s1_req;
    t_mag_req   n_s1_req;
    logic       w_s1_adv;
    logic [ARG_W-1:0] w_t, w_ta, w_tt, w_t2, w_t_ta;
    logic       w_p1, w_p2, w_p3;
    t_phase     w_phase;

    // magnitude pipeline
    logic       w_mag_ready;
    logic       w_rsp_valid;
    t_mag_rsp   w_rsp;

    // output stage
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_set_point;
    t_phase                   r_phase;
    logic signed [DATA_W-1:0] n_set_point;
    logic                     w_out_adv;
    logic                     w_decel;
    logic [VAL_W-1:0]         w_base, w_magx, w_val;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_mode   <= 1'b0;
            r_direction      <= 1'b0;
            r_start_position <= '0;
            r_end_position   <= '0;
            r_accel_time     <= '0;
            r_total_time     <= '0;
            r_accel_rate     <= '0;
            r_cruise_speed   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROFILE_MODE:   r_profile_mode   <= i_cfg_data[0];
                CFG_DIRECTION:      r_direction      <= i_cfg_data[0];
                CFG_START_POSITION: r_start_position <= i_cfg_data;
                CFG_END_POSITION:   r_end_position   <= i_cfg_data;
                CFG_ACCEL_TIME:     r_accel_time     <= i_cfg_data;
                CFG_TOTAL_TIME:     r_total_time     <= i_cfg_data;
                CFG_ACCEL_RATE:     r_accel_rate     <= i_cfg_data;
                CFG_CRUISE_SPEED:   r_cruise_speed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Compare at 33 bits so T + Ta and 2T never wrap.
    always_comb begin
        w_t    = ARG_W'(i_sample_time);
        w_ta   = ARG_W'(r_accel_time);
        w_tt   = ARG_W'(r_total_time);
        w_t2   = {i_sample_time, 1'b0};
        w_t_ta = w_t + w_ta;
        if (!r_profile_mode) begin
            w_p1 = w_t < w_ta;
            w_p2 = !w_p1 && (w_t_ta <= w_tt);
            w_p3 = (w_t_ta > w_tt) && (w_t <= w_tt);
        end else begin
            w_p1 = w_t2 < w_tt;
            w_p2 = 1'b0;
            w_p3 = !w_p1 && (w_t <= w_tt);
        end
        // later phase wins
        if (w_p3)      w_phase = PH_DECEL;
        else if (w_p2) w_phase = PH_CRUISE;
        else if (w_p1) w_phase = PH_ACCEL;
        else           w_phase = PH_NONE;

        n_s1_req.phase = w_phase;
        n_s1_req.quad  = (w_phase != PH_CRUISE);
        n_s1_req.coef  = (w_phase == PH_CRUISE) ? r_cruise_speed : r_accel_rate;
        case (w_phase)
            PH_ACCEL:  n_s1_req.arg = w_t;
            PH_CRUISE: n_s1_req.arg = w_t2 - w_ta;
            PH_DECEL:  n_s1_req.arg = w_tt - w_t;
            default:   n_s1_req.arg = '0;
        endcase
    end

    assign w_s1_adv       = !r_s1_valid || w_mag_ready;
    assign o_sample_ready = w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= i_sample_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) r_s1_req <= n_s1_req;
    end

    tps_mag u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_s1_valid),
        .o_req_ready (w_mag_ready),
        .i_req       (r_s1_req),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (w_out_adv),
        .o_rsp       (w_rsp)
    );

    // Decel subtracts from end, others add to start; direction 1 swaps.
    always_comb begin
        w_decel = (w_rsp.phase == PH_DECEL);
        w_base  = w_decel ? {{(VAL_W-DATA_W){r_end_position[DATA_W-1]}}, r_end_position}
                          : {{(VAL_W-DATA_W){r_start_position[DATA_W-1]}}, r_start_position};
        w_magx  = VAL_W'(w_rsp.mag);
        w_val   = (r_direction ^ w_decel) ? (w_base - w_magx) : (w_base + w_magx);
        if (w_rsp.phase == PH_NONE) begin
            n_set_point = '0;
        end else if (w_val[VAL_W-1] && !(&w_val[VAL_W-2:DATA_W-1])) begin
            n_set_point = {1'b1, {(DATA_W-1){1'b0}}};
        end else if (!w_val[VAL_W-1] && (|w_val[VAL_W-2:DATA_W-1])) begin
            n_set_point = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_set_point = w_val[DATA_W-1:0];
        end
    end

    assign w_out_adv = !r_out_valid || i_result_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_set_point <= n_set_point;
            r_phase     <= w_rsp.phase;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_set_point    = r_set_point;
    assign o_phase        = r_phase;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_phase == PH_NONE |-> r_set_point == '0)
        else $error("phase none with nonzero set point");

    a_cruise_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_phase == PH_CRUISE |-> !r_profile_mode)
        else $error("cruise phase in bang-bang mode");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample_valid && o_sample_ready |=> r_s1_valid)
        else $error("accepted sample not captured");

endmodule

/* tb/sv/trapezoidal_profile_setpoint_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the trapezoidal profile set-point unit.
// Needs tps_pkg and the RTL of trapezoidal_profile_setpoint_unit.
module trapezoidal_profile_setpoint_unit_tb;
    import tps_pkg::*;

    localparam int PIPE_LATENCY  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 25;
    localparam int ITEMS_PER_MIX = 400;

    localparam logic [40:0] POS_MAG_CAP = 41'h100_0000_0000;
    localparam longint      SP_MAX      = 2147483647;
    localparam longint      SP_MIN      = -SP_MAX - 1;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [31:0] set_point;
        t_phase      phase;
    } t_setpoint_item;

    // prof selects a register setting; typed rows carry their own answer
    typedef struct packed {
        logic [2:0]  prof;
        logic [31:0] sample_time;
        logic        typed;
        logic [31:0] set_point;
        t_phase      phase;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_sample_valid;
    logic                 o_sample_ready;
    logic [DATA_W-1:0]    i_sample_time;
    logic                 o_result_valid;
    logic                 i_result_ready;
    logic signed [DATA_W-1:0] o_set_point;
    logic [1:0]           o_phase;

    // register copies used for prediction
    logic               prof_mode;
    logic               prof_dir;
    logic signed [31:0] prof_start;
    logic signed [31:0] prof_end;
    logic [31:0]        prof_accel_time;
    logic [31:0]        prof_total_time;
    logic [31:0]        prof_accel_rate;
    logic [31:0]        prof_cruise_speed;

    t_setpoint_item pending_setpoints [$];
    t_setpoint_item head_setpoint;
    t_directed_row  directed_rows [0:DIRECTED_ROWS-1];
    logic [255:0]   directed_profiles [1:6];

    int tx_idle_pct;
    int rx_idle_pct;
    int errors;
    int cycle_count;
    int samples_sent;
    int settings_applied;
    int phase_count [0:3];

    trapezoidal_profile_setpoint_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_time  (i_sample_time),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_set_point    (o_set_point),
        .o_phase        (o_phase)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // floor(coef * arg / 2^sh), held at the magnitude cap
    function automatic logic [40:0] scaled_mag(logic [31:0] coef, logic [63:0] arg, int sh);
        logic [127:0] wide_coef;
        logic [127:0] prod;
        wide_coef = coef;
        prod = wide_coef * arg;
        prod = prod >> sh;
        if (prod > POS_MAG_CAP)
            return POS_MAG_CAP;
        return prod[40:0];
    endfunction

    function automatic t_setpoint_item predict_setpoint(logic [31:0] sample_t);
        logic [63:0]    tw;
        logic [63:0]    ta;
        logic [63:0]    tt;
        logic [63:0]    sq;
        longint         start_q;
        longint         end_q;
        longint         m;
        longint         pos;
        t_phase         ph;
        t_setpoint_item r;
        tw = sample_t;
        ta = prof_accel_time;
        tt = prof_total_time;
        start_q = prof_start;
        end_q = prof_end;
        ph = PH_NONE;
        pos = 0;
        // later phase overrides an earlier one where they overlap
        if (!prof_mode) begin
            if (tw < ta)
                ph = PH_ACCEL;
            if (tw >= ta && tw + ta <= tt)
                ph = PH_CRUISE;
            if (tw + ta > tt && tw <= tt)
                ph = PH_DECEL;
        end else begin
            if (2 * tw < tt)
                ph = PH_ACCEL;
            else if (tw <= tt)
                ph = PH_DECEL;
        end
        case (ph)
            PH_ACCEL: begin
                sq = tw * tw;
                m = scaled_mag(prof_accel_rate, sq, 2 * FRAC_BITS + 1);
                pos = prof_dir ? start_q - m : start_q + m;
            end
            PH_CRUISE: begin
                m = scaled_mag(prof_cruise_speed, 2 * tw - ta, FRAC_BITS + 1);
                pos = prof_dir ? start_q - m : start_q + m;
            end
            PH_DECEL: begin
                sq = (tt - tw) * (tt - tw);
                m = scaled_mag(prof_accel_rate, sq, 2 * FRAC_BITS + 1);
                pos = prof_dir ? end_q + m : end_q - m;
            end
            default: pos = 0;
        endcase
        if (pos > SP_MAX)
            pos = SP_MAX;
        else if (pos < SP_MIN)
            pos = SP_MIN;
        r.sample_time = sample_t;
        r.set_point = pos[31:0];
        r.phase = ph;
        return r;
    endfunction

    function automatic logic [31:0] rand_span(logic [31:0] small_max);
        case ($urandom_range(19))
            0, 1, 2: return $urandom;
            3, 4:    return 32'h0000_0000;
            5, 6:    return 32'hFFFF_FFFF;
            default: return $urandom_range(small_max);
        endcase
    endfunction

    function automatic logic [31:0] rand_position();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_PROFILE_MODE:   prof_mode = data[0];
            CFG_DIRECTION:      prof_dir = data[0];
            CFG_START_POSITION: prof_start = data;
            CFG_END_POSITION:   prof_end = data;
            CFG_ACCEL_TIME:     prof_accel_time = data;
            CFG_TOTAL_TIME:     prof_total_time = data;
            CFG_ACCEL_RATE:     prof_accel_rate = data;
            CFG_CRUISE_SPEED:   prof_cruise_speed = data;
            default: ;
        endcase
    endtask

    // register i sits at bits [32*i +: 32]
    task automatic apply_profile(logic [255:0] regs);
        for (int r = 0; r < 8; r++)
            write_reg(t_cfg_idx'(r), regs[r*32 +: 32]);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings_applied++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_sample_valid = 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] sample_t, t_setpoint_item expected);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_sample_valid = 1'b0;
            @(negedge i_clk);
        end
        i_sample_valid = 1'b1;
        i_sample_time = sample_t;
        @(posedge i_clk);
        while (!o_sample_ready)
            @(posedge i_clk);
        pending_setpoints = {pending_setpoints, expected};
        phase_count[expected.phase]++;
        samples_sent++;
    endtask

    initial begin
        i_result_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_result_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (pending_setpoints.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual set_point %h phase %0d",
                         $time, o_set_point, o_phase);
            end else begin
                head_setpoint = pending_setpoints.pop_front();
                if (o_set_point !== head_setpoint.set_point) begin
                    errors++;
                    $display("%0t: set_point for t=%h: expected %h actual %h", $time,
                             head_setpoint.sample_time, head_setpoint.set_point, o_set_point);
                end
                if (o_phase !== head_setpoint.phase) begin
                    errors++;
                    $display("%0t: phase for t=%h: expected %0d actual %0d", $time,
                             head_setpoint.sample_time, head_setpoint.phase, o_phase);
                end
            end
        end
    end

    // covers the slowest legal run many times over
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trapezoidal_profile_setpoint_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        t_directed_row  row;
        t_setpoint_item expected;
        logic [2:0]     cur_prof;
        logic [31:0]    r_mode;
        logic [31:0]    r_dir;
        logic [31:0]    r_start;
        logic [31:0]    r_end;
        logic [31:0]    r_ta;
        logic [31:0]    r_tt;
        logic [31:0]    r_acc;
        logic [31:0]    r_v;
        logic [31:0]    sample_t;
        logic [32:0]    span;
        int             mix_items;
        int             batch;

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PROFILE_MODE;
        i_cfg_data = '0;
        i_sample_valid = 1'b0;
        i_sample_time = '0;
        tx_idle_pct = 24;
        rx_idle_pct = 58;
        errors = 0;
        cycle_count = 0;
        samples_sent = 0;
        settings_applied = 0;
        for (int p = 0; p < 4; p++)
            phase_count[p] = 0;
        prof_mode = 1'b0;
        prof_dir = 1'b0;
        prof_start = '0;
        prof_end = '0;
        prof_accel_time = '0;
        prof_total_time = '0;
        prof_accel_rate = '0;
        prof_cruise_speed = '0;

        // cruise, accel, total, accel time, end, start, direction, mode
        directed_profiles[1] = {32'h0002_0000, 32'h0001_0000, 32'h000A_0000, 32'h0002_0000,
                                32'h000A_0000, 32'h0001_0000, 32'h0, 32'h0};
        directed_profiles[2] = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0004_0000, 32'h0003_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0};
        directed_profiles[3] = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0};
        directed_profiles[4] = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0};
        directed_profiles[5] = {32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0001_2345,
                                32'h0004_0000, 32'h0000_0000, 32'h0, 32'h1};
        directed_profiles[6] = {32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                                32'h8000_0000, 32'h0000_0000, 32'h1, 32'h1};

        // registers at reset: only time zero lands in the cruise window
        directed_rows[0]  = '{3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, PH_CRUISE};
        directed_rows[1]  = '{3'd0, 32'h0000_0001, 1'b1, 32'h0000_0000, PH_NONE};
        directed_rows[2]  = '{3'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, PH_NONE};
        // ordinary trapezoid, phase edges
        directed_rows[3]  = '{3'd1, 32'h0000_0000, 1'b1, 32'h0001_0000, PH_ACCEL};
        directed_rows[4]  = '{3'd1, 32'h0001_FFFF, 1'b0, 32'h0, PH_NONE};
        directed_rows[5]  = '{3'd1, 32'h0002_0000, 1'b0, 32'h0, PH_NONE};
        directed_rows[6]  = '{3'd1, 32'h0008_0000, 1'b0, 32'h0, PH_NONE};
        directed_rows[7]  = '{3'd1, 32'h0008_0001, 1'b0, 32'h0, PH_NONE};
        directed_rows[8]  = '{3'd1, 32'h000A_0000, 1'b1, 32'h000A_0000, PH_DECEL};
        // overlapping phases, negative move, full-scale rates
        directed_rows[9]  = '{3'd2, 32'h0000_0000, 1'b1, 32'h8000_0000, PH_ACCEL};
        directed_rows[10] = '{3'd2, 32'h0000_8000, 1'b0, 32'h0, PH_NONE};
        directed_rows[11] = '{3'd2, 32'h0002_0000, 1'b0, 32'h0, PH_NONE};
        directed_rows[12] = '{3'd2, 32'h0004_0000, 1'b1, 32'h7FFF_FFFF, PH_DECEL};
        // all-ones times: magnitude cap and saturation
        directed_rows[13] = '{3'd3, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, PH_ACCEL};
        directed_rows[14] = '{3'd3, 32'h8000_0000, 1'b1, 32'h8000_0000, PH_DECEL};
        directed_rows[15] = '{3'd3, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, PH_DECEL};
        directed_rows[16] = '{3'd4, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, PH_CRUISE};
        // bang-bang, switch at half the move time
        directed_rows[17] = '{3'd5, 32'h0000_0000, 1'b1, 32'h0000_0000, PH_ACCEL};
        directed_rows[18] = '{3'd5, 32'h0001_FFFF, 1'b0, 32'h0, PH_NONE};
        directed_rows[19] = '{3'd5, 32'h0002_0000, 1'b0, 32'h0, PH_NONE};
        directed_rows[20] = '{3'd5, 32'h0004_0000, 1'b1, 32'h0004_0000, PH_DECEL};
        directed_rows[21] = '{3'd5, 32'h0004_0001, 1'b1, 32'h0000_0000, PH_NONE};
        directed_rows[22] = '{3'd6, 32'h7FFF_FFFF, 1'b0, 32'h0, PH_NONE};
        directed_rows[23] = '{3'd6, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, PH_DECEL};
        directed_rows[24] = '{3'd6, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, PH_DECEL};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_prof = 3'd0;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.prof != cur_prof) begin
                wait_idle();
                apply_profile(directed_profiles[row.prof]);
                cur_prof = row.prof;
            end
            if (row.typed) begin
                expected.sample_time = row.sample_time;
                expected.set_point = row.set_point;
                expected.phase = row.phase;
            end else begin
                expected = predict_setpoint(row.sample_time);
            end
            send_sample(row.sample_time, expected);
        end

        for (int mix = 0; mix < 3; mix++) begin
            wait_idle();
            tx_idle_pct = (mix == 0) ? 24 : (mix == 1) ? 58 : 0;
            rx_idle_pct = (mix == 0) ? 58 : (mix == 1) ? 24 : 0;
            mix_items = 0;
            while (mix_items < ITEMS_PER_MIX) begin
                r_mode = $urandom;
                r_dir = $urandom;
                r_start = rand_position();
                r_end = rand_position();
                r_tt = rand_span(32'h0020_0000);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: r_ta = $urandom_range(r_tt >> 1);
                    6, 7:             r_ta = $urandom_range(r_tt, r_tt >> 1);
                    8:                r_ta = rand_span(32'h0010_0000);
                    default:          r_ta = $urandom_range(1) ? r_tt : 32'h0;
                endcase
                r_acc = rand_span(32'h0004_0000);
                r_v = rand_span(32'h0004_0000);
                wait_idle();
                apply_profile({r_v, r_acc, r_tt, r_ta, r_end, r_start, r_dir, r_mode});

                batch = $urandom_range(60, 20);
                for (int k = 0; k < batch; k++) begin
                    case ($urandom_range(9))
                        0: sample_t = $urandom;
                        1: begin
                            case ($urandom_range(7))
                                0:       sample_t = 32'h0;
                                1:       sample_t = prof_accel_time - 1;
                                2:       sample_t = prof_accel_time;
                                3:       sample_t = prof_total_time - prof_accel_time;
                                4:       sample_t = prof_total_time - prof_accel_time + 1;
                                5:       sample_t = prof_total_time >> 1;
                                6:       sample_t = prof_total_time;
                                default: sample_t = prof_total_time + 1;
                            endcase
                        end
                        default: begin
                            // mostly inside the move, a little past its end
                            span = {1'b0, prof_total_time} + (prof_total_time >> 3);
                            if (span[32])
                                span = 33'h0_FFFF_FFFF;
                            sample_t = $urandom_range(span[31:0]);
                        end
                    endcase
                    // now and then drain the pipe before the next item
                    if ($urandom_range(99) == 0)
                        wait_idle();
                    send_sample(sample_t, predict_setpoint(sample_t));
                    mix_items++;
                end
            end
        end

        wait_idle();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);

        $display("Sent %0d time samples (%0d directed) under %0d register settings,",
                 samples_sent, DIRECTED_ROWS, settings_applied);
        $display("predicted phases: none %0d, accelerate %0d, cruise %0d, decelerate %0d.",
                 phase_count[0], phase_count[1], phase_count[2], phase_count[3]);
        if (errors == 0)
            $display("trapezoidal_profile_setpoint_unit_tb: clean");
        else
            $display("trapezoidal_profile_setpoint_unit_tb: errors");
        $finish;
    end

endmodule
